// ===== src/j3d7_pkg.sv =====
// Shared constants and types for the 3-D seven-point Jacobi stencil unit.
package j3d7_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int DEF_MAX_X = 128;
  localparam int DEF_MAX_Y = 128;

  localparam int POS_XY_BITS = 7;
  localparam int POS_Z_BITS = 16;
  localparam int SIZE_XY_BITS = 8;
  localparam int SIZE_Z_BITS = 16;
  localparam int MIN_SIZE = 3;
  localparam int RESET_SIZE = 128;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_Z = 2'd2;

  localparam int OUT_FIELD_BITS = SAMPLE_BITS + 2 * POS_XY_BITS + POS_Z_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS = OUT_TDATA_BITS - OUT_FIELD_BITS;

  // floor(sum/6) = floor(floor(sum/2)/3); the halved sum is biased by a
  // multiple of three so the divide by three runs on an unsigned value
  localparam int SUM_BITS = SAMPLE_BITS + 3;
  localparam int U_BITS = SAMPLE_BITS + 2;
  localparam int DIV_K = U_BITS + 2;
  localparam int RECIP_BITS = DIV_K - 1;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << DIV_K) + 64'd2) / 64'd3;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];
  localparam int LO_BITS = U_BITS / 2;
  localparam int HI_BITS = U_BITS - LO_BITS;
  localparam int PROD_BITS = HI_BITS + RECIP_BITS;
  localparam int FULL_BITS = U_BITS + RECIP_BITS;
  localparam logic signed [SUM_BITS-1:0] DIV_OFFSET =
    SUM_BITS'(3) << (SAMPLE_BITS - 1);

  typedef struct packed {
    logic [POS_XY_BITS-1:0] x;
    logic [POS_XY_BITS-1:0] y;
    logic [POS_Z_BITS-1:0]  z;
    logic                   lastp;
    logic                   endg;
    logic                   border;
    logic [SAMPLE_BITS-1:0] center;
    logic [SAMPLE_BITS-1:0] sample;
  } item_meta_t;

endpackage

// ===== src/j3d7_plane_ram.sv =====
// One plane of sample storage: one write port, two registered read ports.
module j3d7_plane_ram #(
  parameter int DEPTH = j3d7_pkg::DEF_MAX_X * j3d7_pkg::DEF_MAX_Y,
  parameter int AW = $clog2(DEPTH),
  parameter int DW = j3d7_pkg::SAMPLE_BITS
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_a_r;
  logic [DW-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== src/jacobi_3d_seven_point_stencil_unit.sv =====
// Top level of the 3-D seven-point Jacobi stencil unit.
//
// Samples enter on the in_ stream in raster order (x fastest, then y, then z).
// Each beat from plane 1 on yields the result for the same (x,y) one plane
// back: interior points get floor(sum of six face neighbours / 6), points on
// any face of the grid pass through. A beat in the last plane also yields its
// own passthrough result right after. Results leave on the out_ stream with
// their coordinates; tlast marks the final result of a beat, tuser the result
// of the last grid point.
// The cfg_ channel writes size_x (0), size_y (1) and size_z (2); a write to any
// of them restarts the grid at the origin. Write only while the unit is idle.
// Throughput: one beat per cycle while out_tready is high, set by the two-port
// plane RAMs; in the last plane each beat yields two results, so the input
// stalls for the second. Registers: stage 0, sum, bias, multiply and output.
// Reset: sizes are 128 (clamped to MAX_X/MAX_Y), the cursor goes to the
// origin; the plane RAMs are not cleared and need no clearing pass.
// When out_tready is low the pipeline holds, fills its bubbles, and then
// drops in_tready.
module jacobi_3d_seven_point_stencil_unit #(
  parameter int MAX_X = j3d7_pkg::DEF_MAX_X,
  parameter int MAX_Y = j3d7_pkg::DEF_MAX_Y
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // cfg
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [j3d7_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [j3d7_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // in
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [j3d7_pkg::SAMPLE_BITS-1:0]      in_tdata,    // sample
  // out
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [j3d7_pkg::OUT_TDATA_BITS-1:0]   out_tdata,   // value, pos_x, pos_y, pos_z, pad
  output logic                                  out_tlast,   // last_of_run
  output logic                                  out_tuser    // end_of_grid
);

  localparam int B = j3d7_pkg::SAMPLE_BITS;
  localparam int XW = $clog2(MAX_X);
  localparam int YW = $clog2(MAX_Y);
  localparam int ZW = j3d7_pkg::SIZE_Z_BITS;
  localparam int DEPTH = MAX_X * MAX_Y;
  localparam int AW = $clog2(DEPTH);
  localparam int SXW = (XW + 1 > j3d7_pkg::SIZE_XY_BITS) ? XW + 1 : j3d7_pkg::SIZE_XY_BITS;
  localparam int SYW = (YW + 1 > j3d7_pkg::SIZE_XY_BITS) ? YW + 1 : j3d7_pkg::SIZE_XY_BITS;
  localparam int RST_X = (j3d7_pkg::RESET_SIZE < MAX_X) ? j3d7_pkg::RESET_SIZE : MAX_X;
  localparam int RST_Y = (j3d7_pkg::RESET_SIZE < MAX_Y) ? j3d7_pkg::RESET_SIZE : MAX_Y;
  localparam logic [XW-1:0] RST_LAST_X = XW'(RST_X - 1);
  localparam logic [YW-1:0] RST_LAST_Y = YW'(RST_Y - 1);
  localparam logic [ZW-1:0] RST_LAST_Z = ZW'(j3d7_pkg::RESET_SIZE - 1);
  localparam int SW = j3d7_pkg::SUM_BITS;
  localparam int UW = j3d7_pkg::U_BITS;
  localparam int LO = j3d7_pkg::LO_BITS;
  localparam int PW = j3d7_pkg::PROD_BITS;
  localparam int FW = j3d7_pkg::FULL_BITS;
  localparam int PXY = j3d7_pkg::POS_XY_BITS;

  function automatic logic [AW-1:0] plane_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
    return AW'(y) * AW'(MAX_X) + AW'(x);
  endfunction

  // config / cursor
  logic [XW-1:0] lastx_r;
  logic [YW-1:0] lasty_r;
  logic [ZW-1:0] lastz_r;
  logic [XW-1:0] cx_r;
  logic [YW-1:0] cy_r;
  logic [ZW-1:0] cz_r;
  logic [SXW-1:0] sx_raw, sx_eff;
  logic [SYW-1:0] sy_raw, sy_eff;
  logic [ZW-1:0] sz_eff;
  logic cfg_hit;

  // cursor decode
  logic x_wrap, y_wrap, z_wrap;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny, ys;
  logic [ZW-1:0] nz;
  logic [AW-1:0] cur_addr, south_addr, ahead_addr;
  logic acc;

  // pipeline control
  logic [3:0] v_r, v_nxt, adv;
  logic out_free;

  // stage 0 data
  logic cur_slot_r, ahead_slot_r;
  logic [B-1:0] r0a, r0b, r1a, r1b;
  logic [B-1:0] cur_val, south_val, ahead_val;
  logic [B-1:0] center_r, west_r, north_r;
  logic [B-1:0] row_mem [MAX_X];
  j3d7_pkg::item_meta_t m0_r, m1_r, m2_r, m3_r, m0_nxt;

  // arithmetic stages
  logic signed [SW-1:0] s1_a_r, s1_b_r, s2_half;
  logic signed [SW-1:0] s2_biased;
  logic [UW-1:0] s2_u_r;
  logic [PW-1:0] s3_hi_r, s3_lo_r;
  logic [FW-1:0] full_prod;
  logic [B-1:0] quot, avg_val, res_val;

  // output
  logic out_tvalid_r, pend_r, pend_end_r;
  logic [B-1:0] pend_sample_r, value_r;
  logic [PXY-1:0] posx_r, posy_r;
  logic [j3d7_pkg::POS_Z_BITS-1:0] posz_r;
  logic last_r, endg_r;

  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid && (cfg_index == j3d7_pkg::CFG_SIZE_X ||
                                 cfg_index == j3d7_pkg::CFG_SIZE_Y ||
                                 cfg_index == j3d7_pkg::CFG_SIZE_Z);

  always_comb begin
    sx_raw = SXW'(cfg_data[j3d7_pkg::SIZE_XY_BITS-1:0]);
    sy_raw = SYW'(cfg_data[j3d7_pkg::SIZE_XY_BITS-1:0]);
    if (sx_raw < SXW'(j3d7_pkg::MIN_SIZE)) begin
      sx_eff = SXW'(j3d7_pkg::MIN_SIZE);
    end else if (sx_raw > SXW'(MAX_X)) begin
      sx_eff = SXW'(MAX_X);
    end else begin
      sx_eff = sx_raw;
    end
    if (sy_raw < SYW'(j3d7_pkg::MIN_SIZE)) begin
      sy_eff = SYW'(j3d7_pkg::MIN_SIZE);
    end else if (sy_raw > SYW'(MAX_Y)) begin
      sy_eff = SYW'(MAX_Y);
    end else begin
      sy_eff = sy_raw;
    end
    if (cfg_data < ZW'(j3d7_pkg::MIN_SIZE)) begin
      sz_eff = ZW'(j3d7_pkg::MIN_SIZE);
    end else begin
      sz_eff = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lastx_r <= RST_LAST_X;
      lasty_r <= RST_LAST_Y;
      lastz_r <= RST_LAST_Z;
    end else if (cfg_valid) begin
      case (cfg_index)
        j3d7_pkg::CFG_SIZE_X: lastx_r <= XW'(sx_eff - SXW'(1));
        j3d7_pkg::CFG_SIZE_Y: lasty_r <= YW'(sy_eff - SYW'(1));
        j3d7_pkg::CFG_SIZE_Z: lastz_r <= sz_eff - ZW'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    x_wrap = (cx_r == lastx_r);
    y_wrap = (cy_r == lasty_r);
    z_wrap = (cz_r == lastz_r);
    nx = x_wrap ? '0 : cx_r + XW'(1);
    ny = x_wrap ? (y_wrap ? '0 : cy_r + YW'(1)) : cy_r;
    nz = (x_wrap && y_wrap) ? (z_wrap ? '0 : cz_r + ZW'(1)) : cz_r;
    ys = y_wrap ? cy_r : cy_r + YW'(1);
    cur_addr = plane_addr(cx_r, cy_r);
    south_addr = plane_addr(cx_r, ys);
    ahead_addr = plane_addr(nx, ny);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
    end else if (cfg_hit) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
    end else if (acc) begin
      cx_r <= nx;
      cy_r <= ny;
      cz_r <= nz;
    end
  end

  // pipeline advance: a stage moves when empty or when the next one moves
  always_comb begin
    out_free = !out_tvalid_r || (out_tready && !pend_r);
    adv[3] = !v_r[3] || out_free;
    adv[2] = !v_r[2] || adv[3];
    adv[1] = !v_r[1] || adv[2];
    adv[0] = !v_r[0] || adv[1];
    acc = in_tvalid && adv[0];
    v_nxt[0] = adv[0] ? (acc && cz_r != '0) : v_r[0];
    v_nxt[1] = adv[1] ? v_r[0] : v_r[1];
    v_nxt[2] = adv[2] ? v_r[1] : v_r[2];
    v_nxt[3] = adv[3] ? v_r[2] : v_r[3];
  end

  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // even planes in ram0, odd planes in ram1; port a reads the current slot
  // at (x,y) or the previous slot at (x,y+1), port b reads one point ahead
  j3d7_plane_ram #(.DEPTH(DEPTH), .AW(AW), .DW(B)) u_ram0 (
    .clk       (clk),
    .wr_en     (acc && !cz_r[0]),
    .wr_addr   (cur_addr),
    .wr_data   (in_tdata),
    .rd_en     (acc),
    .rd_addr_a (cz_r[0] ? south_addr : cur_addr),
    .rd_addr_b (ahead_addr),
    .rd_data_a (r0a),
    .rd_data_b (r0b)
  );

  j3d7_plane_ram #(.DEPTH(DEPTH), .AW(AW), .DW(B)) u_ram1 (
    .clk       (clk),
    .wr_en     (acc && cz_r[0]),
    .wr_addr   (cur_addr),
    .wr_data   (in_tdata),
    .rd_en     (acc),
    .rd_addr_a (cz_r[0] ? cur_addr : south_addr),
    .rd_addr_b (ahead_addr),
    .rd_data_a (r1a),
    .rd_data_b (r1b)
  );

  assign cur_val = cur_slot_r ? r1a : r0a;
  assign south_val = cur_slot_r ? r0a : r1a;
  assign ahead_val = ahead_slot_r ? r1b : r0b;

  always_comb begin
    m0_nxt.x = PXY'(cx_r);
    m0_nxt.y = PXY'(cy_r);
    m0_nxt.z = cz_r;
    m0_nxt.lastp = z_wrap;
    m0_nxt.endg = z_wrap && x_wrap && y_wrap;
    m0_nxt.border = (cz_r == ZW'(1)) || (cx_r == '0) || x_wrap ||
                    (cy_r == '0) || y_wrap;
    m0_nxt.center = ahead_val;
    m0_nxt.sample = in_tdata;
  end

  // previous-plane window: east is the look-ahead read, center and west are
  // the two before it, north comes back from the row buffer
  always_ff @(posedge clk) begin
    if (acc) begin
      cur_slot_r <= cz_r[0];
      ahead_slot_r <= ~nz[0];
      center_r <= ahead_val;
      west_r <= center_r;
      north_r <= row_mem[cx_r];
      row_mem[cx_r] <= ahead_val;
      m0_r <= m0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_a_r <= SW'(signed'(north_r)) + SW'(signed'(south_val)) +
                SW'(signed'(ahead_val));
      s1_b_r <= SW'(signed'(west_r)) + SW'(signed'(cur_val)) +
                SW'(signed'(m0_r.sample));
      m1_r <= m0_r;
    end
  end

  always_comb begin
    s2_half = (s1_a_r + s1_b_r) >>> 1;
    s2_biased = s2_half + j3d7_pkg::DIV_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_u_r <= s2_biased[UW-1:0];
      m2_r <= m1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_hi_r <= PW'(s2_u_r[UW-1:LO]) * PW'(j3d7_pkg::RECIP);
      s3_lo_r <= PW'(s2_u_r[LO-1:0]) * PW'(j3d7_pkg::RECIP);
      m3_r <= m2_r;
    end
  end

  always_comb begin
    full_prod = (FW'(s3_hi_r) << LO) + FW'(s3_lo_r);
    quot = full_prod[j3d7_pkg::DIV_K +: B];
    avg_val = {~quot[B-1], quot[B-2:0]};
    res_val = m3_r.border ? m3_r.center : avg_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (out_tvalid_r && out_tready && pend_r) begin
      pend_r <= 1'b0;
      value_r <= pend_sample_r;
      posz_r <= posz_r + j3d7_pkg::POS_Z_BITS'(1);
      last_r <= 1'b1;
      endg_r <= pend_end_r;
    end else if (out_free) begin
      out_tvalid_r <= v_r[3];
      pend_r <= v_r[3] && m3_r.lastp;
      value_r <= res_val;
      posx_r <= m3_r.x;
      posy_r <= m3_r.y;
      posz_r <= m3_r.z - j3d7_pkg::POS_Z_BITS'(1);
      last_r <= !m3_r.lastp;
      endg_r <= 1'b0;
      pend_sample_r <= m3_r.sample;
      pend_end_r <= m3_r.endg;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = {{j3d7_pkg::OUT_PAD_BITS{1'b0}}, posz_r, posy_r, posx_r, value_r};
  assign out_tlast = last_r;
  assign out_tuser = endg_r;

endmodule
